### sv/lcpc_pkg.sv
package lcpc_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned TOL_W     = 16;
  localparam int unsigned PCNT_W    = 5;
  localparam int unsigned HCNT_W    = 5;
  localparam int unsigned REG_IDX_W = 8;
  localparam int unsigned ACC_W     = 50;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned WIDE_W    = 66;
  localparam int unsigned SEG_HITS  = 2;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_LINE  = 2'd1;
  localparam logic [1:0] FUNC_POINT = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_PLANE_COUNT = 8'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE   = 8'd1;

  localparam logic [PCNT_W-1:0] PLANE_COUNT_RST = 5'd5;
  localparam logic [TOL_W-1:0]  TOLERANCE_RST   = 16'd66;

  typedef logic [2:0][COORD_W-1:0] vec3_t;

  typedef struct packed {
    logic [1:0]                 func;
    logic [3:0]                 slot;
    logic signed [COORD_W-1:0]  a_x;
    logic signed [COORD_W-1:0]  a_y;
    logic signed [COORD_W-1:0]  a_z;
    logic signed [COORD_W-1:0]  b_x;
    logic signed [COORD_W-1:0]  b_y;
    logic signed [COORD_W-1:0]  b_z;
  } in_item_t;

  typedef struct packed {
    logic                       found;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  start_z;
    logic signed [COORD_W-1:0]  span_x;
    logic signed [COORD_W-1:0]  span_y;
    logic signed [COORD_W-1:0]  span_z;
    logic [HCNT_W-1:0]          hit_count;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
  } mac_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LQ_READ,
    ST_LQ_TEST,
    ST_V1_MUL,
    ST_V1_ACC,
    ST_V1_SAVE,
    ST_V2_MUL,
    ST_V2_ACC,
    ST_EVAL,
    ST_DIV_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_IN_READ,
    ST_IN_MUL,
    ST_IN_ACC,
    ST_IN_EVAL,
    ST_DUP_READ,
    ST_DUP_CMP,
    ST_HIT_WRITE,
    ST_NEXT_PLANE,
    ST_FINISH
  } state_e;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sd2147483647);
    lo = WIDE_W'(-64'sd2147483648);
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[COORD_W-1:0];
  endfunction

  function automatic logic in_tol(input logic signed [WIDE_W-1:0] x,
                                  input logic [TOL_W-1:0] tol);
    logic signed [WIDE_W-1:0] t;
    t = $signed({{(WIDE_W-TOL_W){1'b0}}, tol});
    return (x <= t) && (x >= -t);
  endfunction

  function automatic logic fuzzy_same(input vec3_t u, input vec3_t v,
                                      input logic [TOL_W-1:0] tol);
    logic same;
    same = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (!in_tol(WIDE_W'($signed(u[k])) - WIDE_W'($signed(v[k])), tol)) begin
        same = 1'b0;
      end
    end
    return same;
  endfunction

endpackage

### sv/lcpc_if.sv
interface lcpc_in_if import lcpc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lcpc_out_if import lcpc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lcpc_cfg_if import lcpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/lcpc_mac.sv
module lcpc_mac import lcpc_pkg::*; (
  input  logic                      clk_i,
  input  mac_ctrl_t                 ctrl_i,
  input  logic signed [COORD_W-1:0] op_a_i,
  input  logic signed [COORD_W-1:0] op_b_i,
  output logic signed [PROD_W-1:0]  prod_o,
  output logic signed [ACC_W-1:0]   acc_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_fl;

  // Arithmetic shift floors the Q32.32 product to Q48.16.
  assign prod_fl = prod_q >>> 16;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_W'(op_a_i) * PROD_W'(op_b_i);
    end
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + prod_fl[ACC_W-1:0];
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

### sv/lcpc_div.sv
module lcpc_div import lcpc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [PROD_W-1:0]  dividend_i,
  input  logic signed [COORD_W-1:0] divisor_i,
  output logic                      done_o,
  output logic signed [PROD_W-1:0]  quot_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [PROD_W-1:0] dvd_q, dvd_d;
  logic [COORD_W-1:0] rem_q, rem_d;
  logic [COORD_W-1:0] dsr_q, dsr_d;
  logic              neg_q, neg_d;
  logic [COORD_W:0]  trial;

  assign trial = {rem_q, dvd_q[PROD_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = (dividend_i < 0) ? -dividend_i : dividend_i;
      dsr_d  = (divisor_i < 0) ? -divisor_i : divisor_i;
      neg_d  = dividend_i[PROD_W-1] ^ divisor_i[COORD_W-1];
    end else if (busy_q) begin
      // Restoring step: one quotient bit per cycle, MSB first.
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = COORD_W'(trial - {1'b0, dsr_q});
        dvd_d = {dvd_q[PROD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[COORD_W-1:0];
        dvd_d = {dvd_q[PROD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule

### sv/line_convex_prism_clip_top.sv
// Channel   Dir  Payload                                    Transfer
// cfg_i     in   index, data (plane_count, tolerance)       valid && ready, ready always high
// in_i      in   func, slot, a_x..a_z, b_x..b_z             valid && ready, ready only in idle
// out_o     out  found, start_x..z, span_x..z, hit_count    valid && ready
//
// A load or unused func goes straight to the result; a point query tests up to N planes.
// A line query, for each plane, first checks whether the plane point matches the origin,
// else forms the two dot products and, when needed, divides out the hit per axis (64-step
// divider); then come the containment pass, the duplicate scan over kept hits and the store.
// The multiplier is a single shared unit and the divider is bit-serial.
// Reset clears control state only; table entries are valid once loaded.
// A finished result waits in the output register while the next item is accepted.
module line_convex_prism_clip_top import lcpc_pkg::*; #(
  parameter int unsigned MAX_PLANES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lcpc_cfg_if.sink          cfg_i,
  lcpc_in_if.sink           in_i,
  lcpc_out_if.source        out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_PLANES);
  localparam int unsigned CNT_W = $clog2(MAX_PLANES + 1);

  state_e state_q, state_d;

  logic [PCNT_W-1:0] plane_count_q;
  logic [TOL_W-1:0]  tol_q;

  logic [1:0]        func_q, func_d;
  vec3_t             a_q, a_d;
  vec3_t             b_q, b_d;
  vec3_t             x_q, x_d;
  vec3_t             start_q, start_d;
  vec3_t             second_q, second_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  plane_idx_q, plane_idx_d;
  logic [CNT_W-1:0]  chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]  dup_idx_q, dup_idx_d;
  logic [CNT_W-1:0]  kept_q, kept_d;
  logic [1:0]        comp_q, comp_d;
  logic signed [ACC_W-1:0]   v1_q, v1_d;
  logic signed [COORD_W-1:0] s2_q, s2_d;
  logic              inside_q, inside_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  vec3_t             pt_mem  [MAX_PLANES];
  vec3_t             nm_mem  [MAX_PLANES];
  vec3_t             hit_mem [MAX_PLANES];
  vec3_t             pt_rd_q, nm_rd_q, hit_rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_inner;
  logic              hit_we;

  logic              in_acc;
  logic              load_we;
  logic [CNT_W-1:0]  n_new;

  mac_ctrl_t                 mac_ctrl;
  logic signed [COORD_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic                      div_start;
  logic                      div_done;
  logic signed [PROD_W-1:0]  div_quot;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign load_we   = in_acc && (in_i.data.func == FUNC_LOAD) &&
                     (int'(in_i.data.slot) < MAX_PLANES);
  assign n_new     = (int'(plane_count_q) > MAX_PLANES) ? CNT_W'(MAX_PLANES)
                                                        : CNT_W'(plane_count_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= PLANE_COUNT_RST;
      tol_q         <= TOLERANCE_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_PLANE_COUNT) begin
        plane_count_q <= cfg_i.data[PCNT_W-1:0];
      end else if (cfg_i.index == REG_TOLERANCE) begin
        tol_q <= cfg_i.data[TOL_W-1:0];
      end
    end
  end

  // Plane and hit tables, registered reads.
  assign rd_inner = (state_q == ST_IN_READ) || (state_q == ST_IN_MUL) ||
                    (state_q == ST_IN_ACC) || (state_q == ST_IN_EVAL);
  assign rd_addr  = rd_inner ? chk_idx_q[IDX_W-1:0] : plane_idx_q[IDX_W-1:0];
  assign hit_we   = (state_q == ST_HIT_WRITE) && (int'(kept_q) < MAX_PLANES);

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      pt_mem[IDX_W'(in_i.data.slot)] <= {in_i.data.a_z, in_i.data.a_y, in_i.data.a_x};
      nm_mem[IDX_W'(in_i.data.slot)] <= {in_i.data.b_z, in_i.data.b_y, in_i.data.b_x};
    end
    pt_rd_q <= pt_mem[rd_addr];
    nm_rd_q <= nm_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (hit_we) begin
      hit_mem[kept_q[IDX_W-1:0]] <= x_q;
    end
    hit_rd_q <= hit_mem[dup_idx_q[IDX_W-1:0]];
  end

  lcpc_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  lcpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (s2_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_V1_MUL: begin
        op_a = sat32(WIDE_W'($signed(pt_rd_q[comp_q])) - WIDE_W'($signed(a_q[comp_q])));
        op_b = $signed(nm_rd_q[comp_q]);
      end
      ST_V2_MUL: begin
        op_a = $signed(b_q[comp_q]);
        op_b = $signed(nm_rd_q[comp_q]);
      end
      ST_DIV_MUL: begin
        op_a = sat32(WIDE_W'(v1_q));
        op_b = $signed(b_q[comp_q]);
      end
      ST_IN_MUL: begin
        op_a = sat32(WIDE_W'($signed(x_q[comp_q])) - WIDE_W'($signed(pt_rd_q[comp_q])));
        op_b = $signed(nm_rd_q[comp_q]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    a_d         = a_q;
    b_d         = b_q;
    x_d         = x_q;
    start_d     = start_q;
    second_d    = second_q;
    n_d         = n_q;
    plane_idx_d = plane_idx_q;
    chk_idx_d   = chk_idx_q;
    dup_idx_d   = dup_idx_q;
    kept_d      = kept_q;
    comp_d      = comp_q;
    v1_d        = v1_q;
    s2_d        = s2_q;
    inside_d    = inside_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mac_ctrl    = '0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_d      = in_i.data.func;
          a_d         = {in_i.data.a_z, in_i.data.a_y, in_i.data.a_x};
          b_d         = {in_i.data.b_z, in_i.data.b_y, in_i.data.b_x};
          x_d         = {in_i.data.a_z, in_i.data.a_y, in_i.data.a_x};
          n_d         = n_new;
          plane_idx_d = '0;
          chk_idx_d   = '0;
          kept_d      = '0;
          inside_d    = 1'b1;
          if (n_new == '0) begin
            state_d = ST_FINISH;
          end else if (in_i.data.func == FUNC_LINE) begin
            state_d = ST_LQ_READ;
          end else if (in_i.data.func == FUNC_POINT) begin
            state_d = ST_IN_READ;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_LQ_READ: begin
        state_d = ST_LQ_TEST;
      end
      ST_LQ_TEST: begin
        comp_d           = '0;
        mac_ctrl.acc_clr = 1'b1;
        if (fuzzy_same(pt_rd_q, a_q, tol_q)) begin
          x_d       = pt_rd_q;
          chk_idx_d = '0;
          inside_d  = 1'b1;
          state_d   = ST_IN_READ;
        end else begin
          state_d = ST_V1_MUL;
        end
      end
      ST_V1_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = ST_V1_ACC;
      end
      ST_V1_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = ST_V1_SAVE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_V1_MUL;
        end
      end
      ST_V1_SAVE: begin
        v1_d             = acc;
        comp_d           = '0;
        mac_ctrl.acc_clr = 1'b1;
        state_d          = ST_V2_MUL;
      end
      ST_V2_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = ST_V2_ACC;
      end
      ST_V2_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = ST_EVAL;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_V2_MUL;
        end
      end
      ST_EVAL: begin
        comp_d = '0;
        if (in_tol(WIDE_W'(v1_q), tol_q)) begin
          // Line origin lies on the plane: the plane point is the hit.
          x_d       = pt_rd_q;
          chk_idx_d = '0;
          inside_d  = 1'b1;
          state_d   = ST_IN_READ;
        end else if (in_tol(WIDE_W'(acc), tol_q)) begin
          state_d = ST_NEXT_PLANE;
        end else begin
          s2_d    = sat32(WIDE_W'(acc));
          state_d = ST_DIV_MUL;
        end
      end
      ST_DIV_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          x_d[comp_q] = sat32(WIDE_W'($signed(a_q[comp_q])) + WIDE_W'(div_quot));
          if (comp_q == 2'd2) begin
            chk_idx_d = '0;
            inside_d  = 1'b1;
            state_d   = ST_IN_READ;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = ST_DIV_MUL;
          end
        end
      end
      ST_IN_READ: begin
        comp_d           = '0;
        mac_ctrl.acc_clr = 1'b1;
        state_d          = ST_IN_MUL;
      end
      ST_IN_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = ST_IN_ACC;
      end
      ST_IN_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = ST_IN_EVAL;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_IN_MUL;
        end
      end
      ST_IN_EVAL: begin
        if (WIDE_W'(acc) > $signed({{(WIDE_W-TOL_W){1'b0}}, tol_q})) begin
          inside_d = 1'b0;
          state_d  = (func_q == FUNC_POINT) ? ST_FINISH : ST_NEXT_PLANE;
        end else if ((chk_idx_q + CNT_W'(1)) != n_q) begin
          chk_idx_d = chk_idx_q + CNT_W'(1);
          state_d   = ST_IN_READ;
        end else if (func_q == FUNC_POINT) begin
          state_d = ST_FINISH;
        end else if (kept_q == '0) begin
          state_d = ST_HIT_WRITE;
        end else begin
          dup_idx_d = '0;
          state_d   = ST_DUP_READ;
        end
      end
      ST_DUP_READ: begin
        state_d = ST_DUP_CMP;
      end
      ST_DUP_CMP: begin
        if (fuzzy_same(hit_rd_q, x_q, tol_q)) begin
          state_d = ST_NEXT_PLANE;
        end else if ((dup_idx_q + CNT_W'(1)) == kept_q) begin
          state_d = ST_HIT_WRITE;
        end else begin
          dup_idx_d = dup_idx_q + CNT_W'(1);
          state_d   = ST_DUP_READ;
        end
      end
      ST_HIT_WRITE: begin
        if (int'(kept_q) < MAX_PLANES) begin
          if (kept_q == '0) begin
            start_d = x_q;
          end
          if (kept_q == CNT_W'(1)) begin
            second_d = x_q;
          end
          kept_d = kept_q + CNT_W'(1);
        end
        state_d = ST_NEXT_PLANE;
      end
      ST_NEXT_PLANE: begin
        if ((plane_idx_q + CNT_W'(1)) == n_q) begin
          state_d = ST_FINISH;
        end else begin
          plane_idx_d = plane_idx_q + CNT_W'(1);
          state_d     = ST_LQ_READ;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = '0;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (func_q == FUNC_POINT) begin
            out_d.found = inside_q;
          end else if (func_q == FUNC_LINE) begin
            out_d.hit_count = HCNT_W'(kept_q);
            if (kept_q != '0) begin
              out_d.start_x = $signed(start_q[0]);
              out_d.start_y = $signed(start_q[1]);
              out_d.start_z = $signed(start_q[2]);
            end
            if (kept_q == CNT_W'(SEG_HITS)) begin
              out_d.found  = 1'b1;
              out_d.span_x = sat32(WIDE_W'($signed(second_q[0])) -
                                   WIDE_W'($signed(start_q[0])));
              out_d.span_y = sat32(WIDE_W'($signed(second_q[1])) -
                                   WIDE_W'($signed(start_q[1])));
              out_d.span_z = sat32(WIDE_W'($signed(second_q[2])) -
                                   WIDE_W'($signed(start_q[2])));
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      plane_idx_q <= '0;
      chk_idx_q   <= '0;
      dup_idx_q   <= '0;
      kept_q      <= '0;
      comp_q      <= '0;
      n_q         <= '0;
      func_q      <= FUNC_LOAD;
      inside_q    <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      plane_idx_q <= plane_idx_d;
      chk_idx_q   <= chk_idx_d;
      dup_idx_q   <= dup_idx_d;
      kept_q      <= kept_d;
      comp_q      <= comp_d;
      n_q         <= n_d;
      func_q      <= func_d;
      inside_q    <= inside_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    x_q      <= x_d;
    start_q  <= start_d;
    second_q <= second_d;
    v1_q     <= v1_d;
    s2_q     <= s2_d;
    out_q    <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= n_q)
    else $error("kept hit count exceeds planes in use");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_WAIT))
    else $error("divider finished while sequencer not waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.data.func == FUNC_LOAD)) |=> (state_q == ST_FINISH))
    else $error("load item did not go straight to result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised outside finish state");

endmodule
